// ===== sv/psts_pkg.sv =====
// Shared types, constants and the CRC byte step of the PSI section packetizer.
package psts_pkg;

	localparam int unsigned COUNTER_SLOTS_DEF = 128;
	localparam int unsigned SLOT_CODES = 128;

	localparam logic [7:0] TS_SIZE = 8'd188;
	localparam logic [7:0] SYNC_BYTE = 8'h47;
	localparam logic [7:0] PUSI_FLAG = 8'h40;
	localparam logic [7:0] CC_FLAG = 8'h10;
	localparam logic [7:0] POINTER_FIELD = 8'h00;
	localparam logic [11:0] POS_MAX = 12'hFFF;
	localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [2:0] HDR_LEN = 3'd4;
	localparam logic [2:0] HDR_LEN_PTR = 3'd5;
	localparam logic [2:0] UNIT_LAST_SEC = 3'd0;
	localparam logic [2:0] UNIT_LAST_CRC = 3'd4;

	typedef struct packed {
		logic [7:0] section_byte;
		logic [12:0] pid;
		logic [6:0] counter_slot;
		logic [11:0] section_bytes;
		logic last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] ts_byte;
		logic packet_start;
		logic [7:0] stuffing_after;
		logic last_of_run;
	} out_t;

	function automatic logic [31:0] crc8_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h000000};
		for (int i = 0; i < 8; i++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/psts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module psts_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 128,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/psi_section_ts_packetizer.sv =====
// Top level of the PSI section to transport stream packetizer.
//
// The sec channel takes one section byte per beat, CRC excluded, with its pid,
// counter slot, section length and a last_byte mark. The ts channel gives one
// transport stream byte per beat, with a sync mark, the count of 0xFF stuffing
// bytes that close the packet, and a mark on the final byte caused by each
// input beat. Section length is patched into bytes 1 and 2 and CRC-32/MPEG-2
// is appended after the last byte.
// The first output byte of an input beat passes the emit stage and then the
// output register. Output runs at one byte per cycle through a single byte
// port unless the receiver stalls; a beat that opens a packet adds its header,
// a last beat adds the four CRC bytes, and beats follow back to back.
// The continuity counters live in a RAM read when a beat is accepted and
// written back in the next cycle if it opens a packet; a write that overlaps a read is forwarded.
// After reset the RAM is cleared one entry per cycle, through all
// COUNTER_SLOTS entries; sec_ready stays low during that pass.
// When the receiver stalls, the output register holds its beat and sec_ready
// drops as soon as the current input beat has bytes that cannot move.
module psi_section_ts_packetizer #(
	parameter int unsigned COUNTER_SLOTS = psts_pkg::COUNTER_SLOTS_DEF,
	localparam int unsigned AW = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sec_valid,
	output logic sec_ready,
	input  psts_pkg::in_t sec,
	output logic ts_valid,
	input  logic ts_ready,
	output psts_pkg::out_t ts
);

	logic [31:0] crc_q;
	logic [7:0] fill_q;
	logic [11:0] pos_q;
	logic first_q;
	logic clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic valid_s1;
	logic first_cyc_s1;
	logic [7:0] byte_s1;
	logic [31:0] crc_s1;
	logic hdr_s1;
	logic [2:0] hdr_at_s1;
	logic pusi_s1;
	logic last_s1;
	logic [7:0] stuff_s1;
	logic [12:0] pid_s1;
	logic [AW-1:0] addr_s1;
	logic [2:0] unit_s1;
	logic [2:0] hpos_s1;

	logic [3:0] cc_hold_q;
	logic fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [3:0] fwd_data_q;

	logic ts_valid_q;
	psts_pkg::out_t ts_q;

	logic [AW-1:0] slot_map [psts_pkg::SLOT_CODES];
	logic [AW-1:0] rd_addr;
	logic [3:0] rdata;
	logic [3:0] cc_cur;
	logic hdr_we;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [3:0] ram_wdata;

	logic accept;
	logic [11:0] len;
	logic [7:0] b_patched;
	logic [31:0] crc_new;
	logic [7:0] fill_next;
	logic plan_hdr;
	logic [2:0] plan_hdr_at;
	logic [7:0] plan_stuff;

	logic [2:0] hlen;
	logic in_hdr;
	logic is_last;
	logic [7:0] unit_byte;
	logic [7:0] hdr_byte;
	logic out_can;
	logic emit;
	logic s1_done;
	psts_pkg::out_t emit_data;

	for (genvar i = 0; i < psts_pkg::SLOT_CODES; i++) begin : g_slot_map
		assign slot_map[i] = AW'(i % COUNTER_SLOTS);
	end

	assign rd_addr = slot_map[sec.counter_slot];

	psts_ram #(
		.WIDTH(4),
		.DEPTH(COUNTER_SLOTS)
	) u_cc_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(accept),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		if (first_cyc_s1) begin
			cc_cur = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata;
		end else begin
			cc_cur = cc_hold_q;
		end
		hdr_we = valid_s1 && first_cyc_s1 && hdr_s1;
		ram_we = clr_busy_q || hdr_we;
		ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
		ram_wdata = clr_busy_q ? 4'd0 : cc_cur + 4'd1;
	end

	// Plan of the accepted beat: patched byte, CRC, header place and packet fill.
	always_comb begin
		logic [7:0] f;
		f = fill_q;
		plan_hdr = 1'b0;
		plan_hdr_at = 3'd0;
		len = sec.section_bytes + 12'd1;
		b_patched = sec.section_byte;
		if (pos_q == 12'd1) begin
			b_patched = {sec.section_byte[7:4], len[11:8]};
		end else if (pos_q == 12'd2) begin
			b_patched = len[7:0];
		end
		crc_new = psts_pkg::crc8_step(crc_q, b_patched);
		for (int u = 0; u < 5; u++) begin
			if (u == 0 || sec.last_byte) begin
				if (f == 8'd0) begin
					plan_hdr = 1'b1;
					plan_hdr_at = 3'(u);
					f = first_q ? 8'd5 : 8'd4;
				end
				f = f + 8'd1;
				if (f >= psts_pkg::TS_SIZE) begin
					f = 8'd0;
				end
			end
		end
		plan_stuff = (sec.last_byte && f != 8'd0) ? psts_pkg::TS_SIZE - f : 8'd0;
		fill_next = sec.last_byte ? 8'd0 : f;
	end

	always_comb begin
		hlen = pusi_s1 ? psts_pkg::HDR_LEN_PTR : psts_pkg::HDR_LEN;
		in_hdr = hdr_s1 && unit_s1 == hdr_at_s1 && hpos_s1 < hlen;
		is_last = !in_hdr
			&& unit_s1 == (last_s1 ? psts_pkg::UNIT_LAST_CRC : psts_pkg::UNIT_LAST_SEC);
		case (unit_s1)
			3'd1: unit_byte = crc_s1[31:24];
			3'd2: unit_byte = crc_s1[23:16];
			3'd3: unit_byte = crc_s1[15:8];
			3'd4: unit_byte = crc_s1[7:0];
			default: unit_byte = byte_s1;
		endcase
		case (hpos_s1)
			3'd0: hdr_byte = psts_pkg::SYNC_BYTE;
			3'd1: hdr_byte = (pusi_s1 ? psts_pkg::PUSI_FLAG : 8'h00) | {3'b000, pid_s1[12:8]};
			3'd2: hdr_byte = pid_s1[7:0];
			3'd3: hdr_byte = psts_pkg::CC_FLAG | {4'h0, cc_cur};
			default: hdr_byte = psts_pkg::POINTER_FIELD;
		endcase
		emit_data.ts_byte = in_hdr ? hdr_byte : unit_byte;
		emit_data.packet_start = in_hdr && hpos_s1 == 3'd0;
		emit_data.stuffing_after = is_last ? stuff_s1 : 8'd0;
		emit_data.last_of_run = is_last;
		out_can = !ts_valid_q || ts_ready;
		emit = valid_s1 && out_can;
		s1_done = emit && is_last;
		sec_ready = !clr_busy_q && (!valid_s1 || s1_done);
		accept = sec_valid && sec_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= psts_pkg::CRC_INIT;
			fill_q <= 8'd0;
			pos_q <= 12'd0;
			first_q <= 1'b1;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			valid_s1 <= 1'b0;
			first_cyc_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
			ts_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == AW'(COUNTER_SLOTS - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			fwd_v_q <= hdr_we;
			if (accept) begin
				crc_q <= sec.last_byte ? psts_pkg::CRC_INIT : crc_new;
				fill_q <= fill_next;
				if (sec.last_byte) begin
					pos_q <= 12'd0;
					first_q <= 1'b1;
				end else begin
					if (pos_q != psts_pkg::POS_MAX) begin
						pos_q <= pos_q + 12'd1;
					end
					if (plan_hdr) begin
						first_q <= 1'b0;
					end
				end
				valid_s1 <= 1'b1;
				first_cyc_s1 <= 1'b1;
			end else begin
				first_cyc_s1 <= 1'b0;
				if (s1_done) begin
					valid_s1 <= 1'b0;
				end
			end
			if (emit) begin
				ts_valid_q <= 1'b1;
			end else if (ts_ready) begin
				ts_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= b_patched;
			crc_s1 <= crc_new;
			hdr_s1 <= plan_hdr;
			hdr_at_s1 <= plan_hdr_at;
			pusi_s1 <= first_q;
			last_s1 <= sec.last_byte;
			stuff_s1 <= plan_stuff;
			pid_s1 <= sec.pid;
			addr_s1 <= rd_addr;
			unit_s1 <= 3'd0;
			hpos_s1 <= 3'd0;
		end else if (emit) begin
			if (in_hdr) begin
				hpos_s1 <= hpos_s1 + 3'd1;
			end else begin
				unit_s1 <= unit_s1 + 3'd1;
			end
		end
		if (first_cyc_s1) begin
			cc_hold_q <= cc_cur;
		end
		fwd_addr_q <= addr_s1;
		fwd_data_q <= ram_wdata;
		if (emit) begin
			ts_q <= emit_data;
		end
	end

	assign ts_valid = ts_valid_q;
	assign ts = ts_q;

	a_stuff_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		ts_valid && ts.stuffing_after != 8'd0 |-> ts.last_of_run)
		else $error("Stuffing count on a beat that does not end its run.");

	a_sync_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		ts_valid && ts.packet_start |-> !ts.last_of_run && ts.ts_byte == psts_pkg::SYNC_BYTE)
		else $error("Packet header beat ends a run or lacks the sync byte.");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !sec_ready && !hdr_we)
		else $error("Counter RAM accessed during the clearing pass.");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 && first_cyc_s1)
		else $error("Accepted beat did not load the emit stage.");

endmodule
